// ===== rtl/core/lcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the line centroid steering block
// row geometry, derived widths, register indexes and inter-module structs
// ----------------------------------------------------------------------------
package lcs_pkg;

  // row geometry
  localparam int ROW_WIDTH  = 320;
  localparam int ROW_CENTRE = 160;

  // field widths
  localparam int PIX_W = 8;
  localparam int CFG_W = 8;
  localparam int DRV_W = 9;
  localparam int OFF_W = 9;
  localparam int IDX_W = 2;

  // derived state widths
  localparam int COL_W     = $clog2(ROW_WIDTH + 1);
  localparam int CNT_W     = COL_W;
  localparam int SUM_BOUND = ROW_WIDTH * (ROW_WIDTH + ROW_CENTRE);
  localparam int SUM_W     = $clog2(SUM_BOUND + 1) + 1;
  localparam int MAG_W     = SUM_W;
  localparam int STEP_W    = $clog2(MAG_W + 1);
  localparam int PROD_W    = OFF_W + CFG_W + 1;

  // saturation limits
  localparam int OFF_MAX     = 255;
  localparam int OFF_MIN_MAG = 256;
  localparam int DRV_MAX     = 255;
  localparam int Q8_ROUND    = 255;
  localparam int Q8_SHIFT    = 8;

  // register reset values
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd130;
  localparam logic [CFG_W-1:0] GAIN_RST      = 8'd51;
  localparam logic [CFG_W-1:0] BASE_RST      = 8'd33;

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_GAIN      = 2'd1,
    REG_BASE      = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_ROW,
    ST_DIV,
    ST_MUL,
    ST_DRIVE
  } lcs_state_t;

  // row totals including the pixel in flight
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } row_stats_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/core/lcs_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_accum: per-pixel threshold and centroid accumulation
// counts line pixels and sums their column offsets, clears at row end
// ----------------------------------------------------------------------------
module lcs_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pix_take,
  input  logic [lcs_pkg::PIX_W-1:0]   pixel,
  input  logic                        row_end,
  input  logic [lcs_pkg::CFG_W-1:0]   threshold,
  output lcs_pkg::row_stats_t         stats_nxt
);
  import lcs_pkg::*;

  logic [COL_W-1:0]        column_count_r, column_count_nxt;
  logic signed [SUM_W-1:0] offset_sum_r, offset_sum_nxt;
  logic [CNT_W-1:0]        white_count_r, white_count_nxt;
  logic signed [SUM_W-1:0] col_offset;
  logic                    in_row;
  logic                    is_white;

  assign in_row     = column_count_r < COL_W'(ROW_WIDTH);
  assign is_white   = pixel > threshold;
  assign col_offset = $signed({{(SUM_W-COL_W){1'b0}}, column_count_r}) - SUM_W'(ROW_CENTRE);

  always_comb begin
    stats_nxt.sum   = offset_sum_r;
    stats_nxt.count = white_count_r;
    if (in_row && is_white) begin
      stats_nxt.sum   = offset_sum_r + col_offset;
      stats_nxt.count = white_count_r + CNT_W'(1);
    end
  end

  always_comb begin
    column_count_nxt = column_count_r;
    offset_sum_nxt   = offset_sum_r;
    white_count_nxt  = white_count_r;
    if (pix_take) begin
      if (row_end) begin
        column_count_nxt = '0;
        offset_sum_nxt   = '0;
        white_count_nxt  = '0;
      end else begin
        offset_sum_nxt  = stats_nxt.sum;
        white_count_nxt = stats_nxt.count;
        if (in_row) begin
          column_count_nxt = column_count_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      offset_sum_r   <= '0;
      white_count_r  <= '0;
    end else begin
      column_count_r <= column_count_nxt;
      offset_sum_r   <= offset_sum_nxt;
      white_count_r  <= white_count_nxt;
    end
  end

endmodule

// ===== rtl/core/lcs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_div: iterative signed divider for the row centroid
// restoring division, one quotient bit per cycle, result clamped to 9 bits
// ----------------------------------------------------------------------------
module lcs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  lcs_pkg::row_stats_t               stats,
  output lcs_pkg::div_status_t              status,
  output logic signed [lcs_pkg::OFF_W-1:0]  quotient
);
  import lcs_pkg::*;

  localparam int QX_W = MAG_W + OFF_W;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [MAG_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    dvs_r, dvs_nxt;
  logic                neg_r, neg_nxt;
  logic [CNT_W:0]      shifted;
  logic [CNT_W:0]      trial;
  logic                fits;
  logic [QX_W-1:0]     q_ext;

  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(MAG_W);
      neg_nxt  = stats.sum[SUM_W-1];
      quo_nxt  = stats.sum[SUM_W-1] ? MAG_W'(-stats.sum) : MAG_W'(stats.sum);
      rem_nxt  = '0;
      dvs_nxt  = stats.count;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[MAG_W-2:0], fits};
      rem_nxt  = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // sign restore and clamp to the offset field
  assign q_ext = {{OFF_W{1'b0}}, quo_r};

  always_comb begin
    if (!neg_r) begin
      quotient = (q_ext > QX_W'(OFF_MAX)) ? OFF_W'(OFF_MAX) : $signed(q_ext[OFF_W-1:0]);
    end else begin
      quotient = (q_ext > QX_W'(OFF_MIN_MAG)) ? -OFF_W'(OFF_MIN_MAG)
                                              : -$signed(q_ext[OFF_W-1:0]);
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== rtl/core/line_centroid_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_centroid_steering: proportional steering from the line centroid of a row
// thresholds a camera row, finds the mean line offset and sets two motor drives
// ----------------------------------------------------------------------------
// usage
//   in_*  : one grey pixel per transfer, column 0 first, in_row_end on the last
//   out_* : one result transfer per row: left/right drive, line offset, line lost
//   cfg_* : register writes (threshold, q8 gain, base speed), cfg_ready is
//           always high; write only while no row end is being processed
// throughput and row end sequence
//   ordinary pixels are taken one per cycle, each accumulated as it is taken;
//   after the row end pixel, in_stall stays high while a 19-step restoring
//   divider produces one quotient bit per cycle, then while the clamped
//   quotient is taken, the gain multiply is registered and the drive stage
//   sets the drives and loads the output register
// reset
//   synchronous, active low: accumulators cleared, registers to defaults,
//   no result pending
// stalls
//   a held result stays in the output register while the next row streams in;
//   the drive stage waits there until the register is free
// ----------------------------------------------------------------------------
module line_centroid_steering (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lcs_pkg::PIX_W-1:0]          in_pixel,
  input  logic                               in_row_end,
  // steering results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lcs_pkg::DRV_W-1:0]   out_left_drive,
  output logic signed [lcs_pkg::DRV_W-1:0]   out_right_drive,
  output logic signed [lcs_pkg::OFF_W-1:0]   out_line_offset,
  output logic                               out_line_lost,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcs_pkg::IDX_W-1:0]          cfg_index,
  input  logic [lcs_pkg::CFG_W-1:0]          cfg_data
);
  import lcs_pkg::*;

  localparam int P_W  = PROD_W - Q8_SHIFT;
  localparam int DS_W = P_W + 2;

  lcs_state_t state_r, state_nxt;

  // configuration registers
  logic [CFG_W-1:0] threshold_r, threshold_nxt;
  logic [CFG_W-1:0] gain_r, gain_nxt;
  logic [CFG_W-1:0] base_r, base_nxt;

  // datapath registers
  logic                     lost_r, lost_nxt;
  logic signed [OFF_W-1:0]  off_r, off_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DRV_W-1:0]  left_r, left_nxt;
  logic signed [DRV_W-1:0]  right_r, right_nxt;
  logic signed [OFF_W-1:0]  offset_r, offset_nxt;
  logic                     lost_out_r, lost_out_nxt;

  logic                     pix_take;
  logic                     div_start;
  row_stats_t               stats_nxt;
  div_status_t              div_status;
  logic signed [OFF_W-1:0]  quotient;

  logic signed [PROD_W-1:0] prod_biased;
  logic signed [P_W-1:0]    p_term;
  logic signed [DS_W-1:0]   base_ext;
  logic signed [DS_W-1:0]   left_sum;
  logic signed [DS_W-1:0]   right_sum;
  logic signed [DRV_W-1:0]  left_sat;
  logic signed [DRV_W-1:0]  right_sat;
  logic                     out_free;

  assign in_stall  = (state_r != ST_ROW);
  assign pix_take  = in_valid && !in_stall;
  assign div_start = pix_take && in_row_end;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  lcs_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_take  (pix_take),
    .pixel     (in_pixel),
    .row_end   (in_row_end),
    .threshold (threshold_r),
    .stats_nxt (stats_nxt)
  );

  lcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .stats    (stats_nxt),
    .status   (div_status),
    .quotient (quotient)
  );

  // register write decode
  always_comb begin
    threshold_nxt = threshold_r;
    gain_nxt      = gain_r;
    base_nxt      = base_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold_nxt = cfg_data;
        REG_GAIN:      gain_nxt      = cfg_data;
        REG_BASE:      base_nxt      = cfg_data;
        default:       ;  // index past the register list is dropped
      endcase
    end
  end

  // p = offset * gain / 256, truncated toward zero
  assign prod_biased = prod_r + (prod_r[PROD_W-1] ? PROD_W'(Q8_ROUND) : PROD_W'(0));
  assign p_term      = prod_biased[PROD_W-1:Q8_SHIFT];
  assign base_ext    = $signed({{(DS_W-CFG_W){1'b0}}, base_r});
  assign left_sum    = base_ext + DS_W'(p_term);
  assign right_sum   = base_ext - DS_W'(p_term);

  always_comb begin
    if (left_sum > DS_W'(DRV_MAX)) begin
      left_sat = DRV_W'(DRV_MAX);
    end else if (left_sum < -DS_W'(DRV_MAX)) begin
      left_sat = -DRV_W'(DRV_MAX);
    end else begin
      left_sat = left_sum[DRV_W-1:0];
    end
    if (right_sum > DS_W'(DRV_MAX)) begin
      right_sat = DRV_W'(DRV_MAX);
    end else if (right_sum < -DS_W'(DRV_MAX)) begin
      right_sat = -DRV_W'(DRV_MAX);
    end else begin
      right_sat = right_sum[DRV_W-1:0];
    end
  end

  // sequencer: row stream, divide, gain multiply, drive update
  always_comb begin
    state_nxt     = state_r;
    lost_nxt      = lost_r;
    off_nxt       = off_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    left_nxt      = left_r;
    right_nxt     = right_r;
    offset_nxt    = offset_r;
    lost_out_nxt  = lost_out_r;
    unique case (state_r)
      ST_ROW: begin
        if (div_start) begin
          lost_nxt  = (stats_nxt.count == '0);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          off_nxt   = lost_r ? OFF_W'(0) : quotient;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(off_r * $signed({1'b0, gain_r}));
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        // wait for the output register to drain
        if (out_free) begin
          out_valid_nxt = 1'b1;
          left_nxt      = lost_r ? DRV_W'(0) : left_sat;
          right_nxt     = lost_r ? DRV_W'(0) : right_sat;
          offset_nxt    = off_r;
          lost_out_nxt  = lost_r;
          state_nxt     = ST_ROW;
        end
      end
      default: state_nxt = ST_ROW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ROW;
      out_valid_r <= 1'b0;
      threshold_r <= THRESHOLD_RST;
      gain_r      <= GAIN_RST;
      base_r      <= BASE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      threshold_r <= threshold_nxt;
      gain_r      <= gain_nxt;
      base_r      <= base_nxt;
    end
    lost_r     <= lost_nxt;
    off_r      <= off_nxt;
    prod_r     <= prod_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    offset_r   <= offset_nxt;
    lost_out_r <= lost_out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;
  assign out_line_offset = offset_r;
  assign out_line_lost   = lost_out_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the line centroid steering block
// streams camera rows through the pixel channel with random gaps and output
// stalls, predicts the steering result of each row from a mirror of the
// registers and row state, and compares every result transfer field by field
// ----------------------------------------------------------------------------
module tb;
  import lcs_pkg::*;

  // index outside the register list, writes to it must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  // pause after the last result before touching registers
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 200;
  localparam int RAND_PHASES   = 7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } reg_write_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] left;
    logic signed [DRV_W-1:0] right;
    logic signed [OFF_W-1:0] offset;
    logic                    lost;
  } steer_t;

  // row content patterns
  typedef enum int {
    ROW_NOISE,
    ROW_EDGE,
    ROW_SPARSE,
    ROW_SINGLE,
    ROW_WHITE,
    ROW_BLACK
  } row_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [PIX_W-1:0]        in_pixel = '0;
  logic                    in_row_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DRV_W-1:0] out_left_drive;
  logic signed [DRV_W-1:0] out_right_drive;
  logic signed [OFF_W-1:0] out_line_offset;
  logic                    out_line_lost;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  // stimulus queues and progress counters
  pixel_t     pix_queue[$];
  reg_write_t reg_queue[$];
  steer_t     steer_queue[$];
  int         items_sent = 0;
  int         items_taken = 0;
  int         regs_issued = 0;
  int         regs_done = 0;
  int         fault_count = 0;

  // idle control, calm means no gaps or stalls on that side
  logic in_calm = 1'b0;
  logic out_calm = 1'b0;
  int   pix_wait = 0;
  int   hold_cnt = 0;

  // register mirror and row state of the predictor
  logic [CFG_W-1:0] thr_mirror = THRESHOLD_RST;
  logic [CFG_W-1:0] gain_mirror = GAIN_RST;
  logic [CFG_W-1:0] base_mirror = BASE_RST;
  int               col_pos = 0;
  int               offset_acc = 0;
  int               hit_cnt = 0;

  // threshold of the current phase, used to shape rows around it
  int phase_thr = int'(THRESHOLD_RST);

  line_centroid_steering DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .in_row_end      (in_row_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive),
    .out_line_offset (out_line_offset),
    .out_line_lost   (out_line_lost),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int next_wait(logic calm);
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  // steering prediction for one accepted pixel, queues a result on row end
  function automatic void track_pixel(logic [PIX_W-1:0] pix, logic last);
    int     mean;
    int     p;
    steer_t res;
    // pixels past the row width are not counted
    if (col_pos < ROW_WIDTH) begin
      if (pix > thr_mirror) begin
        offset_acc += col_pos - ROW_CENTRE;
        hit_cnt++;
      end
      col_pos++;
    end
    if (last) begin
      res = '0;
      res.lost = 1'b1;
      if (hit_cnt != 0) begin
        // int division truncates toward zero
        mean = clip(offset_acc / hit_cnt, -OFF_MIN_MAG, OFF_MAX);
        p = (mean * int'(gain_mirror)) / 256;
        res.left   = DRV_W'(clip(int'(base_mirror) + p, -DRV_MAX, DRV_MAX));
        res.right  = DRV_W'(clip(int'(base_mirror) - p, -DRV_MAX, DRV_MAX));
        res.offset = OFF_W'(mean);
        res.lost   = 1'b0;
      end
      steer_queue.push_back(res);
      col_pos = 0;
      offset_acc = 0;
      hit_cnt = 0;
    end
  endfunction

  // pixel driver: predicts each transfer, then presents the next item
  always @(posedge clk) begin
    pixel_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      pix_wait <= 0;
      col_pos = 0;
      offset_acc = 0;
      hit_cnt = 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_pixel(in_pixel, in_row_end);
        items_taken++;
      end
      // a stalled pixel holds its payload
      if (!in_valid || !in_stall) begin
        if (pix_wait != 0) begin
          pix_wait <= pix_wait - 1;
          in_valid <= 1'b0;
        end else if (pix_queue.size() != 0) begin
          item = pix_queue.pop_front();
          in_pixel   <= item.pixel;
          in_row_end <= item.row_end;
          in_valid   <= 1'b1;
          // gap after this pixel's transfer
          pix_wait   <= next_wait(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register write driver, mirror follows each write transfer
  always @(posedge clk) begin
    reg_write_t wr;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      thr_mirror  <= THRESHOLD_RST;
      gain_mirror <= GAIN_RST;
      base_mirror <= BASE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_mirror  <= cfg_data;
          REG_GAIN:      gain_mirror <= cfg_data;
          REG_BASE:      base_mirror <= cfg_data;
          default: ;
        endcase
        regs_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_queue.size() != 0) begin
          wr = reg_queue.pop_front();
          cfg_index <= wr.index;
          cfg_data  <= wr.data;
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each transfer, then may hold out_stall before taking
  // the next one; the hold counts down only while out_valid is high
  always @(posedge clk) begin
    steer_t exp;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (steer_queue.size() == 0) begin
          $error("result transfer with no row end pending");
          fault_count++;
        end else begin
          exp = steer_queue.pop_front();
          if (out_left_drive !== exp.left) begin
            $error("left_drive: expected %0d, got %0d", exp.left, out_left_drive);
            fault_count++;
          end
          if (out_right_drive !== exp.right) begin
            $error("right_drive: expected %0d, got %0d", exp.right, out_right_drive);
            fault_count++;
          end
          if (out_line_offset !== exp.offset) begin
            $error("line_offset: expected %0d, got %0d", exp.offset, out_line_offset);
            fault_count++;
          end
          if (out_line_lost !== exp.lost) begin
            $error("line_lost: expected %0d, got %0d", exp.lost, out_line_lost);
            fault_count++;
          end
        end
        hold_cnt = next_wait(out_calm);
      end else if (out_valid && hold_cnt != 0) begin
        hold_cnt--;
      end
      out_stall <= (hold_cnt != 0);
    end
  end

  task automatic push_pixel(int pix, logic last);
    pixel_t item;
    item.pixel   = pix[PIX_W-1:0];
    item.row_end = last;
    pix_queue.push_back(item);
    items_sent++;
  endtask

  task automatic push_row(int len, row_mode_t mode, int hot);
    int v;
    for (int c = 0; c < len; c++) begin
      case (mode)
        ROW_NOISE:  v = $urandom_range(0, 255);
        ROW_EDGE:   v = clip(phase_thr + int'($urandom_range(0, 4)) - 2, 0, 255);
        ROW_SPARSE: v = ($urandom_range(0, 7) == 0) ? 255 : int'($urandom_range(0, 40));
        ROW_SINGLE: v = (c == hot) ? 255 : 0;
        ROW_WHITE:  v = 255;
        default:    v = 0;
      endcase
      push_pixel(v, c == len - 1);
    end
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int data);
    reg_write_t wr;
    wr.index = idx;
    wr.data  = data[CFG_W-1:0];
    reg_queue.push_back(wr);
    regs_issued++;
  endtask

  task automatic commit_regs();
    while (regs_done != regs_issued) @(posedge clk);
  endtask

  // wait for every pixel and every result, then let the block settle
  task automatic drain();
    while (items_taken != items_sent || steer_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_reg();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    int budget;
    int len;
    int hot;
    int g;
    int b;
    row_mode_t mode;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: line at column 0, threshold boundary, two line pixels
    push_pixel(131, 1'b1);
    push_pixel(130, 1'b1);
    push_pixel(255, 1'b0);
    push_pixel(0, 1'b0);
    push_pixel(255, 1'b1);
    push_pixel(0, 1'b1);
    drain();

    // zero threshold, full gain and base: right drive saturates
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_GAIN, 255);
    write_reg(REG_BASE, 255);
    commit_regs();
    phase_thr = 0;
    push_pixel(1, 1'b1);
    push_pixel(0, 1'b1);
    push_pixel(0, 1'b0);
    push_pixel(0, 1'b0);
    push_pixel(255, 1'b1);
    drain();

    // top threshold: nothing can be line
    write_reg(REG_THRESHOLD, 255);
    write_reg(REG_GAIN, 0);
    write_reg(REG_BASE, 0);
    commit_regs();
    phase_thr = 255;
    push_pixel(255, 1'b1);
    push_pixel(255, 1'b0);
    push_pixel(255, 1'b1);
    drain();

    // zero gain gives plain base drive, spare index write changes nothing
    write_reg(REG_THRESHOLD, 254);
    write_reg(REG_SPARE, 1);
    commit_regs();
    phase_thr = 254;
    push_pixel(255, 1'b1);
    push_pixel(0, 1'b0);
    push_pixel(255, 1'b1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        phase_thr = 200;
        g = 255;
        b = $urandom_range(0, 255);
      end else begin
        phase_thr = pick_reg();
        g = pick_reg();
        b = pick_reg();
      end
      write_reg(REG_BASE, b);
      write_reg(REG_THRESHOLD, phase_thr);
      write_reg(REG_GAIN, g);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom_range(0, 255));
      commit_regs();
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      budget = items_sent + PHASE_ITEMS;

      // one row near or past the full width in some phases: the last column as line,
      // a row running past the width, or random content
      if (ph % 3 == 0) begin
        if (ph == 0) begin
          push_row(ROW_WIDTH, ROW_SINGLE, ROW_WIDTH - 1);
        end else if (ph == 3) begin
          len = ROW_WIDTH + $urandom_range(1, 10);
          push_row(len, row_mode_t'($urandom_range(0, 5)), $urandom_range(0, len - 1));
        end else begin
          len = ROW_WIDTH - 2 + $urandom_range(0, 14);
          hot = $urandom_range(0, 1) ? ROW_WIDTH - 1 : int'($urandom_range(0, len - 1));
          push_row(len, row_mode_t'($urandom_range(0, 5)), hot);
        end
      end

      // mostly short rows so that row ends come often
      while (items_sent < budget) begin
        len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(25, 100))
                                          : int'($urandom_range(1, 24));
        mode = row_mode_t'($urandom_range(0, 5));
        push_row(len, mode, $urandom_range(0, len - 1));
      end
      drain();
    end

    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lcs_pkg.sv
rtl/core/lcs_accum.sv
rtl/core/lcs_div.sv
rtl/core/line_centroid_steering.sv
bench/tb.sv
